### rtl/core/fbdw_pkg.sv
package fbdw_pkg;

	localparam int WIDTH_W        = 12;
	localparam int HEIGHT_W       = 12;
	localparam int ROW_BYTES_W    = 10;
	localparam int PAD_W          = 8;
	localparam int WIN_SIZE_W     = 13;
	localparam int DEF_MAX_ROW_BYTES = 512;
	localparam int DEF_MAX_ROWS      = 4096;
	localparam int QUEUE_DEPTH    = 2;

	typedef enum logic [1:0] {
		REG_WIDTH_PX  = 2'd0,
		REG_HEIGHT_PX = 2'd1,
		REG_ROW_BYTES = 2'd2,
		REG_PAD_PX    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] new_byte;
		logic [7:0] old_byte;
	} in_item_t;

	typedef struct packed {
		logic                  window_valid;
		logic [WIDTH_W-1:0]    window_x;
		logic [HEIGHT_W-1:0]   window_y;
		logic [WIN_SIZE_W-1:0] window_w;
		logic [WIN_SIZE_W-1:0] window_h;
	} out_item_t;

	typedef struct packed {
		logic [WIDTH_W-1:0]     width_px;
		logic [HEIGHT_W-1:0]    height_eff;
		logic [ROW_BYTES_W-1:0] row_bytes_eff;
		logic [PAD_W-1:0]       pad_px;
	} geom_t;

	typedef struct packed {
		logic                   seen;
		logic [ROW_BYTES_W-1:0] least;
		logic [ROW_BYTES_W-1:0] greatest;
		logic [HEIGHT_W-1:0]    first;
		logic [HEIGHT_W-1:0]    last;
	} summary_t;

endpackage

### rtl/core/fbdw_fifo.sv
module fbdw_fifo import fbdw_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/fbdw_front.sv
module fbdw_front import fbdw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  geom_t    geom,
	input  logic     in_valid,
	input  in_item_t in_item,
	output logic     sum_push,
	output summary_t sum_data
);

	logic [ROW_BYTES_W-1:0] col_q, least_q, greatest_q;
	logic [HEIGHT_W-1:0]    row_q, first_q, last_q;
	logic                   seen_q;

	summary_t               nxt;
	logic                   differ, row_end, frame_end;

	assign differ    = (in_item.new_byte != in_item.old_byte);
	assign row_end   = ({1'b0, col_q} + 1'b1) >= {1'b0, geom.row_bytes_eff};
	assign frame_end = row_end && (({1'b0, row_q} + 1'b1) >= {1'b0, geom.height_eff});

	always_comb begin
		nxt.seen     = seen_q;
		nxt.least    = least_q;
		nxt.greatest = greatest_q;
		nxt.first    = first_q;
		nxt.last     = last_q;
		if (differ) begin
			if (!seen_q) begin
				nxt.least    = col_q;
				nxt.greatest = col_q;
				nxt.first    = row_q;
			end else begin
				if (col_q < least_q) begin
					nxt.least = col_q;
				end
				if (col_q > greatest_q) begin
					nxt.greatest = col_q;
				end
				if (row_q < first_q) begin
					nxt.first = row_q;
				end
			end
			nxt.last = row_q;
			nxt.seen = 1'b1;
		end
	end

	assign sum_push = in_valid && frame_end;
	assign sum_data = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			least_q    <= '0;
			greatest_q <= '0;
			first_q    <= '0;
			last_q     <= '0;
			seen_q     <= 1'b0;
		end else if (in_valid) begin
			if (frame_end) begin
				col_q      <= '0;
				row_q      <= '0;
				least_q    <= geom.row_bytes_eff;
				greatest_q <= '0;
				first_q    <= geom.height_eff;
				last_q     <= '0;
				seen_q     <= 1'b0;
			end else begin
				least_q    <= nxt.least;
				greatest_q <= nxt.greatest;
				first_q    <= nxt.first;
				last_q     <= nxt.last;
				seen_q     <= nxt.seen;
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

endmodule

### rtl/core/fbdw_back.sv
module fbdw_back import fbdw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  geom_t     geom,
	input  logic      sum_empty,
	input  summary_t  sum_data,
	output logic      sum_pop,
	input  logic      pop,
	output logic      empty,
	output out_item_t result
);

	logic                   valid_s1, bad_s1;
	logic [ROW_BYTES_W-1:0] x0_s1, x1_s1;
	logic [HEIGHT_W-1:0]    y0_s1, y1_s1;

	logic [5:0]             padb;
	logic [ROW_BYTES_W:0]   gsum;
	logic [HEIGHT_W:0]      lsum;
	logic [ROW_BYTES_W-1:0] x0, x1;
	logic [HEIGHT_W-1:0]    y0, y1;
	logic                   bad;

	logic                   out_full, out_push;
	out_item_t              win;
	logic [WIDTH_W:0]       px_x;
	logic [ROW_BYTES_W:0]   span;
	logic [WIDTH_W+2:0]     px_w, px_end;
	logic [HEIGHT_W:0]      rows;

	assign padb = 6'(({1'b0, geom.pad_px} + 9'd7) >> 3);
	assign gsum = {1'b0, sum_data.greatest} + (ROW_BYTES_W + 1)'(padb);
	assign lsum = {1'b0, sum_data.last} + (HEIGHT_W + 1)'(geom.pad_px);

	always_comb begin
		x0 = (sum_data.least > ROW_BYTES_W'(padb)) ? sum_data.least - ROW_BYTES_W'(padb) : '0;
		x1 = (gsum < {1'b0, geom.row_bytes_eff}) ? gsum[ROW_BYTES_W-1:0]
		                                         : geom.row_bytes_eff - 1'b1;
		y0 = (sum_data.first > HEIGHT_W'(geom.pad_px))
		   ? sum_data.first - HEIGHT_W'(geom.pad_px) : '0;
		y1 = (lsum < {1'b0, geom.height_eff}) ? lsum[HEIGHT_W-1:0]
		                                      : geom.height_eff - 1'b1;
		bad = !sum_data.seen || (geom.width_px == '0) || (geom.height_eff == '0)
		   || (geom.row_bytes_eff == '0);
	end

	assign out_push = valid_s1 && !out_full;
	assign sum_pop  = !sum_empty && (!valid_s1 || !out_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || !out_full) begin
			valid_s1 <= !sum_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (sum_pop) begin
			bad_s1 <= bad;
			x0_s1  <= x0;
			x1_s1  <= x1;
			y0_s1  <= y0;
			y1_s1  <= y1;
		end
	end

	always_comb begin
		px_x   = {x0_s1, 3'b000};
		span   = {1'b0, x1_s1} - {1'b0, x0_s1} + 1'b1;
		px_w   = (WIDTH_W + 3)'({span, 3'b000});
		px_end = (WIDTH_W + 3)'(px_x) + px_w;
		rows   = {1'b0, y1_s1} - {1'b0, y0_s1} + 1'b1;
		win    = '0;
		if (!bad_s1 && (x1_s1 >= x0_s1) && (y1_s1 >= y0_s1)
		    && (px_x < {1'b0, geom.width_px})) begin
			win.window_valid = 1'b1;
			win.window_x     = px_x[WIDTH_W-1:0];
			win.window_y     = y0_s1;
			win.window_h     = rows;
			if (px_end > (WIDTH_W + 3)'(geom.width_px)) begin
				win.window_w = WIN_SIZE_W'(geom.width_px - px_x[WIDTH_W-1:0]);
			end else begin
				win.window_w = px_w[WIN_SIZE_W-1:0];
			end
		end
	end

	fbdw_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (win),
		.rd_en   (pop),
		.rd_data (result),
		.full    (out_full),
		.empty   (empty)
	);

endmodule

### rtl/core/framebuffer_damage_window.sv
// Damage window finder. Byte pairs of the new and previous frame are
// transferred in raster order, one per clock, with no bubbles: full rises only
// when the two-entry frame summary queue backs up, which takes several frames
// ending without the result side draining. The block counts columns and rows
// itself; the transfer of the last byte of a frame queues a bounding-box
// summary, and the padded, clamped window is offered on result through a
// two-entry output queue (summary queue, one compute stage, output queue).
// Registers are written through the APB-style port at byte addresses 0, 4,
// 8 and 12 and must only change while no frame is in flight.
module framebuffer_damage_window import fbdw_pkg::*; #(
	parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
	parameter int MAX_ROWS      = DEF_MAX_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  in_item_t    item,
	output logic        empty,
	input  logic        pop,
	output out_item_t   result
);

	localparam int RowCap    = (MAX_ROW_BYTES > 1023) ? 1023 : MAX_ROW_BYTES;
	localparam int HeightCap = (MAX_ROWS > 4095) ? 4095 : MAX_ROWS;

	logic [WIDTH_W-1:0]     width_px_q;
	logic [HEIGHT_W-1:0]    height_px_q;
	logic [ROW_BYTES_W-1:0] row_bytes_q;
	logic [PAD_W-1:0]       pad_px_q;
	reg_idx_t               reg_idx;

	geom_t                  geom;
	logic                   in_valid, sum_push, sum_pop, sum_empty;
	summary_t               sum_wr, sum_rd;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_px_q  <= '0;
			height_px_q <= '0;
			row_bytes_q <= '0;
			pad_px_q    <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_WIDTH_PX:  width_px_q  <= pwdata[WIDTH_W-1:0];
				REG_HEIGHT_PX: height_px_q <= pwdata[HEIGHT_W-1:0];
				REG_ROW_BYTES: row_bytes_q <= pwdata[ROW_BYTES_W-1:0];
				REG_PAD_PX:    pad_px_q    <= pwdata[PAD_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WIDTH_PX:  prdata = 32'(width_px_q);
			REG_HEIGHT_PX: prdata = 32'(height_px_q);
			REG_ROW_BYTES: prdata = 32'(row_bytes_q);
			REG_PAD_PX:    prdata = 32'(pad_px_q);
			default:       prdata = '0;
		endcase
	end

	always_comb begin
		geom.width_px      = width_px_q;
		geom.pad_px        = pad_px_q;
		geom.row_bytes_eff = (32'(row_bytes_q) > 32'(MAX_ROW_BYTES))
		                   ? ROW_BYTES_W'(RowCap) : row_bytes_q;
		geom.height_eff    = (32'(height_px_q) > 32'(MAX_ROWS))
		                   ? HEIGHT_W'(HeightCap) : height_px_q;
	end

	assign in_valid = push && !full;

	fbdw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.geom     (geom),
		.in_valid (in_valid),
		.in_item  (item),
		.sum_push (sum_push),
		.sum_data (sum_wr)
	);

	fbdw_fifo #(
		.WIDTH ($bits(summary_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_sum_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (sum_push),
		.wr_data (sum_wr),
		.rd_en   (sum_pop),
		.rd_data (sum_rd),
		.full    (full),
		.empty   (sum_empty)
	);

	fbdw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.sum_empty (sum_empty),
		.sum_data  (sum_rd),
		.sum_pop   (sum_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule
